>>> hw/rtl/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg - shared types and constants for the alpha-over blend core
// Pixel beat structs, lane assignment and pipeline geometry.
// ----------------------------------------------------------------------------
package aob_pkg;

	localparam int PIX_W       = 8;
	localparam int WGT_W       = 16;          // fa*255 + ba*(255-fa) <= 255*255
	localparam int NUM_W       = 24;          // colour numerator <= 255*W
	localparam int QUO_W       = 8;           // one restoring step per quotient bit
	localparam int LANE_STAGES = QUO_W + 3;   // products, sum, steps, rounding
	localparam int PIPE_D      = LANE_STAGES + 2;
	localparam int NUM_LANES   = 3;

	localparam int LANE_RED    = 0;
	localparam int LANE_GREEN  = 1;
	localparam int LANE_BLUE   = 2;

	localparam logic [PIX_W-1:0] FULL_SCALE = PIX_W'(255);

	typedef struct packed {
		logic [PIX_W-1:0] fg_red;
		logic [PIX_W-1:0] fg_green;
		logic [PIX_W-1:0] fg_blue;
		logic [PIX_W-1:0] fg_alpha;
		logic [PIX_W-1:0] bg_red;
		logic [PIX_W-1:0] bg_green;
		logic [PIX_W-1:0] bg_blue;
		logic [PIX_W-1:0] bg_alpha;
	} aob_pair_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_alpha;
	} aob_blend_t;

	// Per-beat data that rides alongside the lanes
	typedef struct packed {
		logic             wzero;
		logic [PIX_W-1:0] alpha;
	} aob_side_t;

endpackage

>>> hw/rtl/aob_lane.sv
// ----------------------------------------------------------------------------
// aob_lane - one weighted-sum and rounding divider lane
// Forms fc*fa_w + bc*ba_w and divides it by den, rounding half up, with one
// restoring step per pipeline stage.
// ----------------------------------------------------------------------------
module aob_lane (
	input  logic                            clk,
	input  logic [aob_pkg::LANE_STAGES-1:0] adv,
	input  logic [aob_pkg::PIX_W-1:0]       fc,
	input  logic [aob_pkg::PIX_W-1:0]       bc,
	input  logic [aob_pkg::WGT_W-1:0]       fa_w,
	input  logic [aob_pkg::WGT_W-1:0]       ba_w,
	input  logic [aob_pkg::WGT_W-1:0]       den,
	output logic [aob_pkg::PIX_W-1:0]       quo
);
	import aob_pkg::*;

	logic [NUM_W-1:0] prod_f_s2, prod_b_s2;
	logic [WGT_W-1:0] den_s2;
	logic [NUM_W-1:0] num_s3;
	logic [WGT_W-1:0] den_s3;

	// Divider stages, indexed by step (stage s4 onwards)
	logic [QUO_W-1:0][NUM_W-1:0] div_rem_s;
	logic [QUO_W-1:0][WGT_W-1:0] div_den_s;
	logic [QUO_W-1:0][QUO_W-1:0] div_quo_s;

	logic [PIX_W-1:0] quo_s12;
	logic [NUM_W-1:0] rem_last;
	logic [WGT_W-1:0] den_last;
	logic             round_up;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			prod_f_s2 <= NUM_W'(fc) * NUM_W'(fa_w);
			prod_b_s2 <= NUM_W'(bc) * NUM_W'(ba_w);
			den_s2    <= den;
		end
		if (adv[1]) begin
			num_s3 <= prod_f_s2 + prod_b_s2;
			den_s3 <= den_s2;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [NUM_W-1:0] rem_in;
		logic [NUM_W-1:0] trial;
		logic [WGT_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;

		if (k == 0) begin : g_first
			assign rem_in = num_s3;
			assign den_in = den_s3;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = div_rem_s[k-1];
			assign den_in = div_den_s[k-1];
			assign quo_in = div_quo_s[k-1];
		end

		assign trial = NUM_W'(den_in) << (QUO_W - 1 - k);

		always_ff @(posedge clk) begin
			if (adv[k+2]) begin
				if (rem_in >= trial) begin
					div_rem_s[k] <= rem_in - trial;
					div_quo_s[k] <= quo_in | (QUO_W'(1) << (QUO_W - 1 - k));
				end else begin
					div_rem_s[k] <= rem_in;
					div_quo_s[k] <= quo_in;
				end
				div_den_s[k] <= den_in;
			end
		end
	end

	// Remainder is below den here, so it fits the weight width
	assign rem_last = div_rem_s[QUO_W-1];
	assign den_last = div_den_s[QUO_W-1];
	assign round_up = {rem_last[WGT_W-1:0], 1'b0} >= {1'b0, den_last};

	always_ff @(posedge clk) begin
		if (adv[QUO_W+2]) begin
			quo_s12 <= div_quo_s[QUO_W-1] + PIX_W'(round_up);
		end
	end

	assign quo = quo_s12;

endmodule

>>> hw/rtl/aob_merge.sv
// ----------------------------------------------------------------------------
// aob_merge - lane merge and output register
// Gathers the colour lane quotients, clears colour for a fully transparent
// pair and attaches the blended alpha carried beside the lanes.
// ----------------------------------------------------------------------------
module aob_merge (
	input  logic                                                  clk,
	input  logic                                                  load,
	input  aob_pkg::aob_side_t                                    side,
	input  logic [aob_pkg::NUM_LANES-1:0][aob_pkg::PIX_W-1:0]     quo,
	output aob_pkg::aob_blend_t                                   blend
);
	import aob_pkg::*;

	aob_blend_t blend_s13;

	always_ff @(posedge clk) begin
		if (load) begin
			// zero weight: colour lanes divided by nothing, drop them
			blend_s13.out_red   <= side.wzero ? '0 : quo[LANE_RED];
			blend_s13.out_green <= side.wzero ? '0 : quo[LANE_GREEN];
			blend_s13.out_blue  <= side.wzero ? '0 : quo[LANE_BLUE];
			blend_s13.out_alpha <= side.alpha;
		end
	end

	assign blend = blend_s13;

endmodule

>>> hw/rtl/alpha_over_blend_core.sv
// ----------------------------------------------------------------------------
// alpha_over_blend_core - straight-alpha RGBA "over" compositor
// Three colour lanes divide in parallel, alpha rides beside them, and a
// merge stage assembles the output pixel.
// ----------------------------------------------------------------------------
// Usage:
//   pair  / pair_valid  / pair_stall  : foreground and background pixel in.
//   blend / blend_valid / blend_stall : composited pixel out.
//   A beat moves when valid is high and stall is low.
// An accepted pair beat reaches blend_valid through one stage
// for the alpha weights, two for the lane products and sum, eight for the
// restoring divider (one quotient bit per stage), one for rounding and one
// for the merge/output register. Throughput is one pixel per cycle while
// blend_stall is low, set by the fully pipelined divider.
// Each stage holds only while the stage after it is full and held, so empty
// slots close up under a blend_stall and pair_stall rises only once all 13
// stages hold pixels.
// Reset clears every stage valid; no pixel is in flight after reset.
// ----------------------------------------------------------------------------
module alpha_over_blend_core (
	input  logic                clk,
	input  logic                arst_n,
	input  aob_pkg::aob_pair_t  pair,
	input  logic                pair_valid,
	output logic                pair_stall,
	output aob_pkg::aob_blend_t blend,
	output logic                blend_valid,
	input  logic                blend_stall
);
	import aob_pkg::*;

	logic [PIPE_D-1:0] vld_q;
	logic [PIPE_D:0]   ready;

	aob_pair_t        pix_s1;
	logic [WGT_W-1:0] fa_w_s1, ba_w_s1;
	logic             wzero_s1;
	logic [WGT_W-1:0] wgt;

	logic [WGT_W-1:0] ba_bias;
	logic [WGT_W-1:0] ba_sum;
	logic [PIX_W-1:0] alpha_mix;

	aob_side_t [LANE_STAGES-1:0] side_s;
	aob_side_t                   side_in;

	logic [NUM_LANES-1:0][PIX_W-1:0] lane_fc, lane_bc, lane_quo;
	logic [NUM_LANES-1:0][WGT_W-1:0] lane_den;

	// Ready chain: a stage loads when empty or when the next one loads
	for (genvar k = 0; k < PIPE_D; k++) begin : g_ready
		assign ready[k] = !vld_q[k] || ready[k+1];
	end
	assign ready[PIPE_D] = !blend_stall;

	assign pair_stall  = !ready[0];
	assign blend_valid = vld_q[PIPE_D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_D; k++) begin
				if (ready[k]) begin
					vld_q[k] <= (k == 0) ? pair_valid : vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: alpha weights
	always_ff @(posedge clk) begin
		if (ready[0]) begin
			pix_s1   <= pair;
			fa_w_s1  <= WGT_W'(pair.fg_alpha) * WGT_W'(FULL_SCALE);
			ba_w_s1  <= WGT_W'(pair.bg_alpha) * WGT_W'(FULL_SCALE - pair.fg_alpha);
			wzero_s1 <= (pair.fg_alpha == '0) && (pair.bg_alpha == '0);
		end
	end

	assign wgt = fa_w_s1 + ba_w_s1;

	// Round ba_w/255 half up as floor(x/255) with x = ba_w + 127;
	// below 2^16, floor(x/255) is (x + 1 + (x >> 8)) >> 8
	assign ba_bias   = ba_w_s1 + WGT_W'(127);
	assign ba_sum    = ba_w_s1 + WGT_W'(128) + (ba_bias >> PIX_W);
	assign alpha_mix = pix_s1.fg_alpha + ba_sum[WGT_W-1:PIX_W];

	always_comb begin
		lane_fc[LANE_RED]    = pix_s1.fg_red;
		lane_bc[LANE_RED]    = pix_s1.bg_red;
		lane_den[LANE_RED]   = wgt;
		lane_fc[LANE_GREEN]  = pix_s1.fg_green;
		lane_bc[LANE_GREEN]  = pix_s1.bg_green;
		lane_den[LANE_GREEN] = wgt;
		lane_fc[LANE_BLUE]   = pix_s1.fg_blue;
		lane_bc[LANE_BLUE]   = pix_s1.bg_blue;
		lane_den[LANE_BLUE]  = wgt;
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		aob_lane u_lane (
			.clk  (clk),
			.adv  (ready[LANE_STAGES:1]),
			.fc   (lane_fc[l]),
			.bc   (lane_bc[l]),
			.fa_w (fa_w_s1),
			.ba_w (ba_w_s1),
			.den  (lane_den[l]),
			.quo  (lane_quo[l])
		);
	end

	// Side data follows the lanes stage for stage
	assign side_in = '{wzero: wzero_s1, alpha: alpha_mix};

	always_ff @(posedge clk) begin
		for (int j = 0; j < LANE_STAGES; j++) begin
			if (ready[j+1]) begin
				side_s[j] <= (j == 0) ? side_in : side_s[j-1];
			end
		end
	end

	aob_merge u_merge (
		.clk   (clk),
		.load  (ready[PIPE_D-1]),
		.side  (side_s[LANE_STAGES-1]),
		.quo   (lane_quo),
		.blend (blend)
	);

`ifndef SYNTHESIS
	// Input holds off only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> (&vld_q))
		else $error("pair_stall with an empty pipeline slot");

	// A free-running receiver never backs up the source
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!blend_stall |-> !pair_stall)
		else $error("pair_stall while the output drains");

	// Occupancy follows accepted and delivered beats
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(vld_q) == $past($countones(vld_q))
			+ $past(int'(pair_valid && !pair_stall))
			- $past(int'(blend_valid && !blend_stall))))
		else $error("pixel lost or duplicated in the pipeline");
`endif

endmodule
